FILE: hdl/tfr_pkg.sv
// Shared constants and types for the telemetry frame receiver.
package tfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int STORE_LEN = 21;
    localparam int POS_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'h7B;
    localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h7D;

    // byte_position values: last stored data byte and checksum byte
    localparam logic [POS_W-1:0] POS_LAST_DATA = 5'd21;
    localparam logic [POS_W-1:0] POS_CHECK     = 5'd22;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL = 1'b1;

    // decoded frame; stop_flag sits in the lowest bits
    typedef struct packed {
        logic        [WORD_W-1:0] battery_mv;
        logic signed [WORD_W-1:0] rate_z;
        logic signed [WORD_W-1:0] rate_y;
        logic signed [WORD_W-1:0] rate_x;
        logic signed [WORD_W-1:0] acc_z;
        logic signed [WORD_W-1:0] acc_y;
        logic signed [WORD_W-1:0] acc_x;
        logic signed [WORD_W-1:0] vel_z;
        logic signed [WORD_W-1:0] vel_y;
        logic signed [WORD_W-1:0] vel_x;
        logic        [BYTE_W-1:0] stop_flag;
    } tfr_frame_t;

    localparam int OUT_W = $bits(tfr_frame_t);

    typedef struct packed {
        logic       frame_good;
        tfr_frame_t frame;
    } tfr_status_t;

endpackage

FILE: hdl/tfr_parser.sv
// Frame hunter: head search, byte store, checksum and tail check.
module tfr_parser
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_en,
    input  logic [tfr_pkg::BYTE_W-1:0] rx_byte,
    input  logic [tfr_pkg::BYTE_W-1:0] head_byte,
    input  logic [tfr_pkg::BYTE_W-1:0] tail_byte,
    output tfr_pkg::tfr_status_t       status
);
    import tfr_pkg::*;

    logic              in_frame_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [BYTE_W-1:0] xor_reg;
    logic [BYTE_W-1:0] store_reg [STORE_LEN];

    logic shift_en;
    logic closing;

    assign shift_en = byte_en && in_frame_reg && (pos_reg <= POS_LAST_DATA);
    assign closing  = in_frame_reg && (pos_reg > POS_CHECK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            xor_reg      <= '0;
        end
        else if (byte_en)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == head_byte)
                begin
                    in_frame_reg <= 1'b1;
                    pos_reg      <= POS_W'(1);
                    xor_reg      <= rx_byte;
                end
            end
            else if (!closing)
            begin
                xor_reg <= xor_reg ^ rx_byte;
                pos_reg <= pos_reg + POS_W'(1);
            end
            else
            begin
                in_frame_reg <= 1'b0;
                pos_reg      <= '0;
                xor_reg      <= '0;
            end
        end
    end

    // shift line: frame byte 1 ends up in entry 0
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < STORE_LEN - 1; i++)
            begin
                store_reg[i] <= store_reg[i+1];
            end
            store_reg[STORE_LEN-1] <= rx_byte;
        end
    end

    always_comb
    begin
        status.frame_good = byte_en && closing && (rx_byte == tail_byte) && (xor_reg == '0);
        status.frame.stop_flag  = store_reg[0];
        status.frame.vel_x      = {store_reg[1],  store_reg[2]};
        status.frame.vel_y      = {store_reg[3],  store_reg[4]};
        status.frame.vel_z      = {store_reg[5],  store_reg[6]};
        status.frame.acc_x      = {store_reg[7],  store_reg[8]};
        status.frame.acc_y      = {store_reg[9],  store_reg[10]};
        status.frame.acc_z      = {store_reg[11], store_reg[12]};
        status.frame.rate_x     = {store_reg[13], store_reg[14]};
        status.frame.rate_y     = {store_reg[15], store_reg[16]};
        status.frame.rate_z     = {store_reg[17], store_reg[18]};
        status.frame.battery_mv = {store_reg[19], store_reg[20]};
    end

endmodule

FILE: hdl/telemetry_frame_receiver.sv
// Top level of the telemetry frame receiver: config registers, parser, output register.
//
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata) takes one received serial byte
//   per word. The block hunts for head_byte, collects the 23 bytes after it,
//   checks byte 22 against the XOR of bytes 0..21 and byte 23 against
//   tail_byte. A good frame produces one master word carrying the stop flag,
//   nine signed sensor words and the battery word; a bad frame produces none.
//   Latency: the result word is valid the cycle after the closing byte is
//   accepted. Throughput: one byte per cycle while s_tready is high, set by
//   the parser updating once per accepted byte and feeding one output register.
//   Stall: the output register holds its word while m_tready is low; s_tready
//   stays high while the register is empty or being drained, so bytes keep
//   flowing until a finished word waits unclaimed.
//   Reset (rst_n low, asynchronous): hunting restarts, output register empties,
//   head_byte returns to 0x7B and tail_byte to 0x7D.
//   Config: cfg_we writes cfg_data into register cfg_addr (0 head, 1 tail);
//   a new value applies from the next byte on.
module telemetry_frame_receiver
(
    input  logic                          clk,
    input  logic                          rst_n,
    // config write port
    input  logic                          cfg_we,
    input  logic [tfr_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [tfr_pkg::BYTE_W-1:0]    cfg_data,
    // byte input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tfr_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    // frame output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // low to high: stop_flag, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z,
    // rate_x, rate_y, rate_z, battery_mv
    output logic [tfr_pkg::OUT_W-1:0]     m_tdata
);
    import tfr_pkg::*;

    logic [BYTE_W-1:0] head_reg;
    logic [BYTE_W-1:0] tail_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    tfr_frame_t        out_data_reg;
    logic              byte_en;
    tfr_status_t       status;

    // accept while the output register is empty or draining this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign byte_en  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= HEAD_RESET;
            tail_reg <= TAIL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_HEAD: head_reg <= cfg_data;
                REG_TAIL: tail_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    tfr_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .rx_byte   (s_tdata),
        .head_byte (head_reg),
        .tail_byte (tail_reg),
        .status    (status)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (status.frame_good)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // load a finished frame; it can only arrive when the register is free
    always_ff @(posedge clk)
    begin
        if (status.frame_good)
        begin
            out_data_reg <= status.frame;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: hdl/tfr_checker.sv
// Port-level checker for the telemetry frame receiver, bound to the top level.
module tfr_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [tfr_pkg::OUT_W-1:0]  m_tdata
);
    import tfr_pkg::*;

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // no byte taken while a finished word waits unclaimed
    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output register full");

    // a word only appears right after a byte was taken
    a_rise_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("output word appeared without an input byte");

    // a drained register stays empty unless a byte came in
    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("output word repeated after drain");

endmodule

bind telemetry_frame_receiver tfr_checker u_tfr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
